// File: hdl/sepq_pkg.sv
// shared types, command codes and defaults for the sorted event priority queue
package sepq_pkg;

    localparam int SEPQ_CAPACITY = 64;

    localparam int CMD_W   = 2;
    localparam int TIME_W  = 32;
    localparam int ETYPE_W = 8;
    localparam int PLD_W   = 32;
    localparam int OCC_W   = 7;

    localparam logic [CMD_W-1:0] CMD_ENQUEUE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEQUEUE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK    = 2'd2;

    typedef struct packed {
        logic [TIME_W-1:0]  ev_time;
        logic [ETYPE_W-1:0] ev_type;
        logic [PLD_W-1:0]   payload;
    } entry_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } dp_cmd_t;

endpackage

// File: hdl/sepq_ctrl.sv
// handshake controller: sequences capture, execute and result delivery
module sepq_ctrl import sepq_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    output logic    m_tvalid,
    input  logic    m_tready,
    output dp_cmd_t dp_cmd
);

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        s_tready       = 1'b0;
        dp_cmd.capture = 1'b0;
        dp_cmd.execute = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready       = 1'b1;
                dp_cmd.capture = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // result register must be free or draining this cycle
                if (!m_valid_reg || m_tready) begin
                    dp_cmd.execute = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (dp_cmd.execute) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_tvalid = m_valid_reg;

endmodule

// File: hdl/sepq_datapath.sv
// sorted slot row with parallel key compare, shift insert/remove and result register
module sepq_datapath import sepq_pkg::*; #(
    parameter int CAPACITY = SEPQ_CAPACITY
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  dp_cmd_t            dp_cmd,
    input  logic [CMD_W-1:0]   in_command,
    input  entry_t             in_entry,
    output logic               out_ok,
    output logic               out_is_empty,
    output entry_t             out_head,
    output logic [OCC_W-1:0]   out_occupancy
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CMD_W-1:0] cmd_reg;
    entry_t           new_reg;
    entry_t           slot_reg  [CAPACITY];
    entry_t           slot_next [CAPACITY];
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CAPACITY-1:0] ge;

    logic             ok_reg;
    logic             empty_reg;
    entry_t           head_reg;
    logic [OCC_W-1:0] occ_reg;

    logic is_enq, is_deq, full, empty, do_enq, do_deq, op_ok;
    entry_t head_next;

    always_ff @(posedge aclk) begin
        if (dp_cmd.capture) begin
            cmd_reg <= in_command;
            new_reg <= in_entry;
        end
    end

    assign is_enq = (cmd_reg == CMD_ENQUEUE);
    assign is_deq = (cmd_reg == CMD_DEQUEUE);
    assign full   = (count_reg == CNT_W'(CAPACITY));
    assign empty  = (count_reg == '0);
    assign do_enq = is_enq && !full;
    assign do_deq = is_deq && !empty;
    assign op_ok  = is_enq ? !full : (is_deq ? !empty : 1'b1);

    always_comb begin
        count_next = count_reg;
        if (do_enq) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_deq) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_slot
        // unused slots and slots with a larger key sit at or after the insert point
        assign ge[i] = (CNT_W'(i) >= count_reg) ||
                       ({slot_reg[i].ev_time, slot_reg[i].ev_type} >
                        {new_reg.ev_time, new_reg.ev_type});

        always_comb begin
            slot_next[i] = slot_reg[i];
            if (do_enq && ge[i]) begin
                if (i > 0) begin
                    slot_next[i] = ge[(i > 0) ? i - 1 : 0] ? slot_reg[(i > 0) ? i - 1 : 0]
                                                           : new_reg;
                end else begin
                    slot_next[i] = new_reg;
                end
            end else if (do_deq && (i < CAPACITY - 1)) begin
                slot_next[i] = slot_reg[(i < CAPACITY - 1) ? i + 1 : i];
            end
        end

        always_ff @(posedge aclk) begin
            if (dp_cmd.execute) begin
                slot_reg[i] <= slot_next[i];
            end
        end
    end

    assign head_next = (count_next == '0) ? '0 : slot_next[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (dp_cmd.execute) begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (dp_cmd.execute) begin
            ok_reg    <= op_ok;
            empty_reg <= (count_next == '0);
            head_reg  <= head_next;
            occ_reg   <= OCC_W'(count_next);
        end
    end

    assign out_ok        = ok_reg;
    assign out_is_empty  = empty_reg;
    assign out_head      = head_reg;
    assign out_occupancy = occ_reg;

endmodule

// File: hdl/sorted_event_priority_queue.sv
// top level of the sorted event priority queue: ports, controller and datapath
//
// Bounded priority queue of up to CAPACITY events held in ascending order of
// (event_time, event_type); equal keys keep their arrival order. Each input
// transaction carries a command in s_tuser (enqueue, dequeue, peek; the spare
// code acts as peek) and returns exactly one result transaction with the ok
// flag, the empty flag, the head entry (zeros when empty) and the occupancy.
// A full enqueue or an empty dequeue leaves the queue unchanged with ok low.
// Each transaction first registers the command and event, then executes in
// a step in which every slot compares its key against the new event in parallel
// and the whole slot row shifts to insert or remove. The next transaction is
// taken while a finished result still waits on the master side; execution
// holds only while the result register is occupied and not being drained.
// Slots beyond the occupancy are never reported, so the slot row needs no
// clearing after reset.
module sorted_event_priority_queue import sepq_pkg::*; #(
    parameter int CAPACITY = SEPQ_CAPACITY
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // event_time[31:0], event_type[39:32], event_payload[71:40]
    input  logic [1:0]  s_tuser,   // command[1:0]
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // head_time[31:0], head_type[39:32], head_payload[71:40],
                                   // occupancy[78:72], zero fill[79]
    output logic [1:0]  m_tuser    // ok[0], is_empty[1]
);

    dp_cmd_t          dp_cmd;
    entry_t           in_entry;
    entry_t           out_head;
    logic             out_ok;
    logic             out_is_empty;
    logic [OCC_W-1:0] out_occupancy;

    // unpack the event from the input transaction
    assign in_entry.ev_time = s_tdata[31:0];
    assign in_entry.ev_type = s_tdata[39:32];
    assign in_entry.payload = s_tdata[71:40];

    // handshake sequencing
    sepq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .dp_cmd   (dp_cmd)
    );

    // sorted slot row and result register
    sepq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .dp_cmd        (dp_cmd),
        .in_command    (s_tuser),
        .in_entry      (in_entry),
        .out_ok        (out_ok),
        .out_is_empty  (out_is_empty),
        .out_head      (out_head),
        .out_occupancy (out_occupancy)
    );

    // pack the result transaction
    assign m_tdata = {1'b0, out_occupancy, out_head.payload, out_head.ev_type, out_head.ev_time};
    assign m_tuser = {out_is_empty, out_ok};

endmodule

// File: bench/sorted_event_priority_queue_tb.sv
// self-checking testbench for the sorted event priority queue with its own ordering predictor
module sorted_event_priority_queue_tb;
    import sepq_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;   // unused code, behaves as peek
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 400;
    localparam int DRAIN_TAIL  = 8;
    localparam int PRINT_LIMIT = 20;

    typedef struct packed {
        logic               ok;
        logic               is_empty;
        logic [TIME_W-1:0]  head_time;
        logic [ETYPE_W-1:0] head_type;
        logic [PLD_W-1:0]   head_payload;
        logic [OCC_W-1:0]   occupancy;
    } queue_status_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata  = '0;   // event_time[31:0], event_type[39:32], event_payload[71:40]
    logic [1:0]  s_tuser  = '0;   // command[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;         // head_time[31:0], head_type[39:32], head_payload[71:40],
                                  // occupancy[78:72], zero fill[79]
    logic [1:0]  m_tuser;         // ok[0], is_empty[1]

    // predictor state: sorted copy of the queue contents, head at index 0
    entry_t        sorted_events[$];
    queue_status_t pending_status[$];
    queue_status_t oldest_status;

    int  mismatches    = 0;
    int  cycle_count   = 0;
    int  commands_sent = 0;
    int  results_seen  = 0;
    int  full_rejects  = 0;
    int  empty_rejects = 0;
    int  peak_occupancy = 0;

    // idling control
    bit  tx_quiet      = 1'b0;
    bit  rx_quiet      = 1'b0;
    int  rx_left       = 0;
    int  hold_off_reqs = 0;
    int  hold_off_done = 0;

    sorted_event_priority_queue #(
        .CAPACITY(SEPQ_CAPACITY)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("run stopped after %0d cycles with %0d results outstanding",
                     cycle_count, pending_status.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // true when the stored event sorts strictly after the new one
    function automatic bit sorts_after(input entry_t stored, input entry_t incoming);
        if (stored.ev_time != incoming.ev_time)
            return stored.ev_time > incoming.ev_time;
        return stored.ev_type > incoming.ev_type;
    endfunction

    function automatic queue_status_t apply_queue_cmd(input logic [CMD_W-1:0] cmd,
                                                      input entry_t ev);
        queue_status_t st;
        int pos;
        st.ok = 1'b1;
        if (cmd == CMD_ENQUEUE) begin
            if (sorted_events.size() >= SEPQ_CAPACITY) begin
                st.ok = 1'b0;
                full_rejects++;
            end else begin
                // equal keys go behind existing ones to keep arrival order
                pos = 0;
                while (pos < sorted_events.size() && !sorts_after(sorted_events[pos], ev))
                    pos++;
                sorted_events.insert(pos, ev);
            end
        end else if (cmd == CMD_DEQUEUE) begin
            if (sorted_events.size() == 0) begin
                st.ok = 1'b0;
                empty_rejects++;
            end else begin
                void'(sorted_events.pop_front());
            end
        end
        st.is_empty  = (sorted_events.size() == 0);
        st.occupancy = OCC_W'(sorted_events.size());
        if (sorted_events.size() > peak_occupancy)
            peak_occupancy = sorted_events.size();
        if (st.is_empty) begin
            st.head_time    = '0;
            st.head_type    = '0;
            st.head_payload = '0;
        end else begin
            st.head_time    = sorted_events[0].ev_time;
            st.head_type    = sorted_events[0].ev_type;
            st.head_payload = sorted_events[0].payload;
        end
        return st;
    endfunction

    function automatic int pick_gap(input bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 45);
    endfunction

    // keys lean toward small values and extremes so ties come up often
    function automatic entry_t random_event();
        entry_t ev;
        case ($urandom_range(0, 3))
            0: ev.ev_time = $urandom;
            1: ev.ev_time = $urandom_range(0, 7);
            2: ev.ev_time = $urandom_range(0, 1) ? 32'hFFFF_FFFF - $urandom_range(0, 1)
                                                 : 32'd0 + $urandom_range(0, 1);
            default: ev.ev_time = 32'h8000_0000 + $urandom_range(0, 3);
        endcase
        case ($urandom_range(0, 2))
            0: ev.ev_type = ETYPE_W'($urandom_range(0, 255));
            1: ev.ev_type = ETYPE_W'($urandom_range(0, 2));
            default: ev.ev_type = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        endcase
        ev.payload = $urandom;
        return ev;
    endfunction

    function automatic entry_t make_event(input logic [TIME_W-1:0] t,
                                          input logic [ETYPE_W-1:0] ty,
                                          input logic [PLD_W-1:0] pl);
        entry_t ev;
        ev.ev_time = t;
        ev.ev_type = ty;
        ev.payload = pl;
        return ev;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_LIMIT)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got %0h expected %0h",
                                      results_seen, name, got, want));
    endtask

    // one command transaction; valid is left high so back-to-back sends need no drop
    task automatic send_item(input logic [CMD_W-1:0] cmd, input entry_t ev);
        int gap;
        gap = pick_gap(tx_quiet);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {ev.payload, ev.ev_type, ev.ev_time};
        do @(posedge aclk); while (!s_tready);
        pending_status.push_back(apply_queue_cmd(cmd, ev));
        commands_sent++;
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (pending_status.size() != 0) @(posedge aclk);
        repeat (DRAIN_TAIL) @(posedge aclk);
    endtask

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_off_reqs != hold_off_done) begin
            hold_off_done = hold_off_reqs;
            rx_left = LONG_HOLD;
        end
        if (rx_left > 0) begin
            m_tready <= 1'b0;
            rx_left--;
        end else begin
            m_tready <= 1'b1;
            rx_left = pick_gap(rx_quiet);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_status.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with nothing expected",
                                          results_seen));
            end else begin
                oldest_status = pending_status.pop_front();
                check_field("ok", 32'(m_tuser[0]), 32'(oldest_status.ok));
                check_field("is_empty", 32'(m_tuser[1]), 32'(oldest_status.is_empty));
                check_field("head_time", m_tdata[31:0], oldest_status.head_time);
                check_field("head_type", 32'(m_tdata[39:32]), 32'(oldest_status.head_type));
                check_field("head_payload", m_tdata[71:40], oldest_status.head_payload);
                check_field("occupancy", 32'(m_tdata[78:72]), 32'(oldest_status.occupancy));
            end
            results_seen++;
        end
    end

    task automatic test_empty_queue();
        send_item(CMD_PEEK, make_event(32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF));
        send_item(CMD_DEQUEUE, make_event(32'd0, 8'd0, 32'd0));
        send_item(CMD_SPARE, random_event());
        wait_drain();
    endtask

    // extremes of the keys, type as tie breaker and arrival order on equal keys
    task automatic test_sort_order();
        int i;
        send_item(CMD_ENQUEUE, make_event(32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF));
        send_item(CMD_ENQUEUE, make_event(32'd0, 8'd0, 32'd0));
        send_item(CMD_ENQUEUE, make_event(32'd5, 8'd7, 32'hAAAA_0001));
        send_item(CMD_ENQUEUE, make_event(32'd5, 8'd3, 32'hBBBB_0002));
        send_item(CMD_ENQUEUE, make_event(32'd5, 8'd7, 32'hCCCC_0003));
        send_item(CMD_ENQUEUE, make_event(32'd0, 8'd0, 32'h5555_5555));
        send_item(CMD_SPARE, random_event());
        for (i = 0; i < 7; i++)
            send_item(CMD_DEQUEUE, random_event());
        wait_drain();
    endtask

    task automatic test_fill_and_overflow();
        int i;
        for (i = 0; i < SEPQ_CAPACITY; i++)
            send_item(CMD_ENQUEUE, random_event());
        // both carry extreme keys: the first would go ahead of every larger key, the second at the tail if taken
        send_item(CMD_ENQUEUE, make_event(32'd0, 8'd0, 32'h1234_5678));
        send_item(CMD_ENQUEUE, make_event(32'hFFFF_FFFF, 8'hFF, 32'h8765_4321));
        send_item(CMD_PEEK, random_event());
        for (i = 0; i <= SEPQ_CAPACITY; i++)
            send_item(CMD_DEQUEUE, random_event());
        wait_drain();
    endtask

    // receiver holds off while commands keep coming, so the input must stall
    task automatic test_backpressure();
        int i;
        rx_quiet      <= 1'b0;
        hold_off_reqs <= hold_off_reqs + 1;
        tx_quiet = 1'b1;
        for (i = 0; i < 40; i++)
            send_item((i % 5 == 4) ? CMD_PEEK : CMD_ENQUEUE, random_event());
        tx_quiet = 1'b0;
        wait_drain();
    endtask

    task automatic test_random_traffic(input int count, input int enq_pct,
                                       input int deq_pct, input bit quiet);
        int i;
        int r;
        logic [CMD_W-1:0] cmd;
        tx_quiet = quiet;
        rx_quiet <= quiet;
        for (i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < enq_pct)
                cmd = CMD_ENQUEUE;
            else if (r < enq_pct + deq_pct)
                cmd = CMD_DEQUEUE;
            else
                cmd = ($urandom_range(0, 3) == 0) ? CMD_SPARE : CMD_PEEK;
            send_item(cmd, random_event());
        end
        tx_quiet = 1'b0;
        wait_drain();
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_queue();
        test_sort_order();
        test_fill_and_overflow();
        test_backpressure();
        test_random_traffic(220, 75, 15, 1'b0);
        test_random_traffic(180, 45, 45, 1'b1);
        test_random_traffic(160, 15, 75, 1'b0);
        test_random_traffic(160, 50, 40, 1'b0);

        $display("covered %0d commands and %0d checked results, peak occupancy %0d of %0d",
                 commands_sent, results_seen, peak_occupancy, SEPQ_CAPACITY);
        $display("refused %0d enqueues on a full queue and %0d dequeues on an empty one",
                 full_rejects, empty_rejects);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
